// ===== rtl/tcq_pkg.sv =====
package tcq_pkg;

  localparam int unsigned ENTRIES = 32;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned ADDR_W  = 4;

  localparam logic [2:0] ACT_STORE  = 3'd0;
  localparam logic [2:0] ACT_LOOKUP = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_TICK   = 3'd3;
  localparam logic [2:0] ACT_TRIM   = 3'd4;

  localparam logic [1:0] REG_PER_KEY  = 2'd0;
  localparam logic [1:0] REG_TOTAL    = 2'd1;
  localparam logic [1:0] REG_LIFETIME = 2'd2;

  localparam logic [5:0]  PER_KEY_RST  = 6'd2;
  localparam logic [5:0]  TOTAL_RST    = 6'd32;
  localparam logic [31:0] LIFETIME_RST = 32'd86400;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] key_id;
    logic [31:0] handle;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic        found;
    logic [31:0] out_handle;
    logic [5:0]  entry_count;
    logic        last;
  } out_t;

  typedef struct packed {
    logic ins;
    logic clr;
  } cell_ctrl_t;

  typedef struct packed {
    logic        valid;
    logic        match;
    logic [31:0] key;
    logic [31:0] handle;
    logic [31:0] age;
    logic [31:0] ord_age;
  } cell_view_t;

endpackage

// ===== rtl/tcq_cell.sv =====
module tcq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcq_pkg::cell_ctrl_t ctrl_i,
  input  logic [31:0]         key_i,
  input  logic [31:0]         handle_i,
  input  logic [31:0]         now_i,
  input  logic [31:0]         seq_i,
  input  logic [31:0]         cmp_key_i,
  output tcq_pkg::cell_view_t view_o
);

  logic        valid_q;
  logic [31:0] key_q;
  logic [31:0] handle_q;
  logic [31:0] stamp_q;
  logic [31:0] order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.ins) begin
      valid_q <= 1'b1;
    end else if (ctrl_i.clr) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins) begin
      key_q    <= key_i;
      handle_q <= handle_i;
      stamp_q  <= now_i;
      order_q  <= seq_i;
    end
  end

  always_comb begin
    view_o.valid   = valid_q;
    view_o.match   = valid_q && (key_q == cmp_key_i);
    view_o.key     = key_q;
    view_o.handle  = handle_q;
    view_o.age     = now_i - stamp_q;
    view_o.ord_age = seq_i - order_q;
  end

endmodule

// ===== rtl/ticket_cache_with_quotas.sv =====
// Ticket cache: a row of ENTRIES entry cells scanned by one sequencer, one cell per
// cycle. After the accepting edge the input stalls while the action runs. A lookup
// or remove is one scan over all ENTRIES cells. A store with a nonzero handle or a
// trim takes a check step, a scan of all cells and a return to the check per
// eviction for the total limit, an insert step for a store when both limits are
// nonzero, then one key scan that finds no key over quota, plus two scans for each
// per-key eviction (find the smallest key over quota, then its oldest entry).
// Released handles are queued and delivered after the action ends, then the final
// result, all carrying the entry count after the action; each passes a read state
// and a load state that waits while a held result is stalled, so a tick runs only these.
// No input is taken until the final result has been loaded into the output register.
module ticket_cache_with_quotas #(
  parameter int unsigned ENTRIES = tcq_pkg::ENTRIES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tcq_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tcq_pkg::out_t               out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcq_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = tcq_pkg::CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TOT_CHK, ST_TOT_SCAN, ST_INSERT, ST_PK_SCAN, ST_PK_OLD,
    ST_LOOK_SCAN, ST_REM_SCAN, ST_EMIT_RD, ST_EMIT_LD, ST_FINAL
  } state_e;

  state_e            state_q;
  logic [5:0]        pkl_q, total_q;
  logic [31:0]       life_q;
  logic [31:0]       now_q, seq_q;
  logic [CNT_W-1:0]  cnt_q, limit_q;
  logic [IDX_W-1:0]  idx_q, best_idx_q;
  logic [31:0]       best_age_q, best_ord_q, best_handle_q, cand_q;
  logic              have_q, ins_q, found_q;
  logic [31:0]       key_q, handle_q, answer_q;
  logic [IDX_W:0]    wptr_q, rptr_q;
  logic [31:0]       rdata_q;
  logic [31:0]       rel_mem [ENTRIES];
  logic              out_valid_q;
  tcq_pkg::out_t     out_q;

  tcq_pkg::cell_ctrl_t ctrl [ENTRIES];
  tcq_pkg::cell_view_t view [ENTRIES];
  logic [ENTRIES-1:0]  match_vec, valid_vec;
  logic [31:0]         bcast_key;
  tcq_pkg::cell_view_t cur;
  logic [CNT_W-1:0]    key_cnt, eff_total;
  logic [IDX_W-1:0]    free_idx;
  logic                free_found;
  logic                last_idx, cur_older, cur_newer, out_free, accept;
  logic                out_load;
  logic                ins_en, clr_en;
  logic [IDX_W-1:0]    clr_idx;

  assign pready = 1'b1;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = out_free && ((state_q == ST_EMIT_LD) || (state_q == ST_FINAL));

  always_comb begin
    case (paddr[3:2])
      tcq_pkg::REG_PER_KEY:  prdata = {26'd0, pkl_q};
      tcq_pkg::REG_TOTAL:    prdata = {26'd0, total_q};
      tcq_pkg::REG_LIFETIME: prdata = life_q;
      default:               prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkl_q   <= tcq_pkg::PER_KEY_RST;
      total_q <= tcq_pkg::TOTAL_RST;
      life_q  <= tcq_pkg::LIFETIME_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        tcq_pkg::REG_PER_KEY:  pkl_q   <= pwdata[5:0];
        tcq_pkg::REG_TOTAL:    total_q <= pwdata[5:0];
        tcq_pkg::REG_LIFETIME: life_q  <= pwdata;
        default: ;
      endcase
    end
  end

  assign eff_total = (total_q < CNT_W'(ENTRIES)) ? total_q : CNT_W'(ENTRIES);

  always_comb begin
    case (state_q)
      ST_PK_SCAN: bcast_key = view[idx_q].key;
      ST_PK_OLD:  bcast_key = cand_q;
      default:    bcast_key = key_q;
    endcase
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tcq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl[g]),
      .key_i     (key_q),
      .handle_i  (handle_q),
      .now_i     (now_q),
      .seq_i     (seq_q),
      .cmp_key_i (bcast_key),
      .view_o    (view[g])
    );
    assign match_vec[g] = view[g].match;
    assign valid_vec[g] = view[g].valid;
    assign ctrl[g].ins  = ins_en && (free_idx == IDX_W'(g));
    assign ctrl[g].clr  = clr_en && (clr_idx == IDX_W'(g));
  end

  assign cur      = view[idx_q];
  assign key_cnt  = CNT_W'($countones(match_vec));
  assign last_idx = (idx_q == IDX_W'(ENTRIES - 1));
  assign cur_older = (cur.age > best_age_q) ||
                     ((cur.age == best_age_q) && (cur.ord_age > best_ord_q));
  assign cur_newer = (best_age_q > cur.age) ||
                     ((best_age_q == cur.age) && (best_ord_q > cur.ord_age));

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!valid_vec[i] && !free_found) begin
        free_idx   = IDX_W'(i);
        free_found = 1'b1;
      end
    end
  end

  // release decision for the current cycle
  logic             rel_cur_upd;
  logic [31:0]      rel_handle;
  always_comb begin
    ins_en      = (state_q == ST_INSERT);
    clr_en      = 1'b0;
    clr_idx     = idx_q;
    rel_handle  = cur.handle;
    rel_cur_upd = 1'b0;
    case (state_q)
      ST_TOT_SCAN: begin
        rel_cur_upd = cur.valid && (!have_q || cur_older);
        if (last_idx) begin
          clr_en     = 1'b1;
          clr_idx    = rel_cur_upd ? idx_q : best_idx_q;
          rel_handle = rel_cur_upd ? cur.handle : best_handle_q;
        end
      end
      ST_PK_OLD: begin
        rel_cur_upd = cur.match && (!have_q || cur_older);
        if (last_idx) begin
          clr_en     = 1'b1;
          clr_idx    = rel_cur_upd ? idx_q : best_idx_q;
          rel_handle = rel_cur_upd ? cur.handle : best_handle_q;
        end
      end
      ST_LOOK_SCAN: clr_en = cur.valid && (cur.age > life_q);
      ST_REM_SCAN:  clr_en = cur.match;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (clr_en) begin
      rel_mem[wptr_q[IDX_W-1:0]] <= rel_handle;
    end
    if (state_q == ST_EMIT_RD) begin
      rdata_q <= rel_mem[rptr_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      now_q         <= '0;
      seq_q         <= '0;
      cnt_q         <= '0;
      limit_q       <= '0;
      idx_q         <= '0;
      best_idx_q    <= '0;
      best_age_q    <= '0;
      best_ord_q    <= '0;
      best_handle_q <= '0;
      cand_q        <= '0;
      have_q        <= 1'b0;
      ins_q         <= 1'b0;
      found_q       <= 1'b0;
      key_q         <= '0;
      handle_q      <= '0;
      answer_q      <= '0;
      wptr_q        <= '0;
      rptr_q        <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      if (clr_en) begin
        wptr_q <= wptr_q + 1'b1;
        cnt_q  <= cnt_q - 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            key_q    <= in_data_i.key_id;
            handle_q <= in_data_i.handle;
            found_q  <= 1'b0;
            answer_q <= '0;
            idx_q    <= '0;
            have_q   <= 1'b0;
            ins_q    <= 1'b0;
            case (in_data_i.action)
              tcq_pkg::ACT_STORE: begin
                if (in_data_i.handle == 32'd0) begin
                  state_q <= ST_EMIT_RD;
                end else if (total_q == 6'd0 || pkl_q == 6'd0) begin
                  limit_q <= eff_total;
                  state_q <= ST_TOT_CHK;
                end else begin
                  limit_q <= eff_total - 1'b1;
                  ins_q   <= 1'b1;
                  state_q <= ST_TOT_CHK;
                end
              end
              tcq_pkg::ACT_LOOKUP: state_q <= ST_LOOK_SCAN;
              tcq_pkg::ACT_REMOVE: state_q <= ST_REM_SCAN;
              tcq_pkg::ACT_TICK: begin
                now_q   <= now_q + 32'd1;
                state_q <= ST_EMIT_RD;
              end
              tcq_pkg::ACT_TRIM: begin
                limit_q <= eff_total;
                state_q <= ST_TOT_CHK;
              end
              default: state_q <= ST_EMIT_RD;
            endcase
          end
        end
        ST_TOT_CHK: begin
          idx_q  <= '0;
          have_q <= 1'b0;
          if (cnt_q > limit_q) begin
            state_q <= ST_TOT_SCAN;
          end else if (ins_q) begin
            state_q <= ST_INSERT;
          end else begin
            state_q <= ST_PK_SCAN;
          end
        end
        ST_TOT_SCAN, ST_PK_OLD: begin
          if (rel_cur_upd) begin
            best_idx_q    <= idx_q;
            best_age_q    <= cur.age;
            best_ord_q    <= cur.ord_age;
            best_handle_q <= cur.handle;
          end
          if (last_idx) begin
            idx_q   <= '0;
            have_q  <= 1'b0;
            state_q <= (state_q == ST_TOT_SCAN) ? ST_TOT_CHK : ST_PK_SCAN;
          end else begin
            idx_q <= idx_q + 1'b1;
            if (rel_cur_upd) begin
              have_q <= 1'b1;
            end
          end
        end
        ST_INSERT: begin
          cnt_q   <= cnt_q + 1'b1;
          seq_q   <= seq_q + 32'd1;
          idx_q   <= '0;
          have_q  <= 1'b0;
          state_q <= ST_PK_SCAN;
        end
        ST_PK_SCAN: begin
          // pick the smallest key that is over its quota
          if (cur.valid && (key_cnt > pkl_q) && (!have_q || cur.key < cand_q)) begin
            cand_q <= cur.key;
          end
          if (last_idx) begin
            idx_q  <= '0;
            have_q <= 1'b0;
            if (have_q || (cur.valid && (key_cnt > pkl_q))) begin
              state_q <= ST_PK_OLD;
            end else begin
              state_q <= ST_EMIT_RD;
            end
          end else begin
            idx_q <= idx_q + 1'b1;
            if (cur.valid && (key_cnt > pkl_q) && (!have_q || cur.key < cand_q)) begin
              have_q <= 1'b1;
            end
          end
        end
        ST_LOOK_SCAN: begin
          if (!clr_en && cur.match && (!have_q || cur_newer)) begin
            have_q     <= 1'b1;
            best_age_q <= cur.age;
            best_ord_q <= cur.ord_age;
            found_q    <= 1'b1;
            answer_q   <= cur.handle;
          end
          idx_q <= idx_q + 1'b1;
          if (last_idx) begin
            state_q <= ST_EMIT_RD;
          end
        end
        ST_REM_SCAN: begin
          idx_q <= idx_q + 1'b1;
          if (last_idx) begin
            state_q <= ST_EMIT_RD;
          end
        end
        ST_EMIT_RD: begin
          state_q <= (rptr_q == wptr_q) ? ST_FINAL : ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          if (out_free) begin
            out_valid_q       <= 1'b1;
            out_q.kind        <= 1'b1;
            out_q.found       <= 1'b0;
            out_q.out_handle  <= rdata_q;
            out_q.entry_count <= cnt_q;
            out_q.last        <= 1'b0;
            rptr_q            <= rptr_q + 1'b1;
            state_q           <= ST_EMIT_RD;
          end
        end
        ST_FINAL: begin
          if (out_free) begin
            out_valid_q       <= 1'b1;
            out_q.kind        <= 1'b0;
            out_q.found       <= found_q;
            out_q.out_handle  <= answer_q;
            out_q.entry_count <= cnt_q;
            out_q.last        <= 1'b1;
            rptr_q            <= '0;
            wptr_q            <= '0;
            state_q           <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/tb_ticket_cache_with_quotas.sv =====
module tb_ticket_cache_with_quotas;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSLOT = tcq_pkg::ENTRIES;
  localparam int unsigned AW    = tcq_pkg::ADDR_W;

  // action codes the block does not define
  localparam logic [2:0] ACT_RSVD_LO = 3'd5;
  localparam logic [2:0] ACT_RSVD_HI = 3'd7;

  class ticket_scoreboard;
    bit            valid_q[NSLOT];
    logic [31:0]   key_q[NSLOT];
    logic [31:0]   hdl_q[NSLOT];
    logic [31:0]   stamp_q[NSLOT];
    logic [31:0]   ord_q[NSLOT];
    logic [31:0]   now_ticks;
    logic [31:0]   seq_cnt;
    logic [5:0]    per_key_lim;
    logic [5:0]    total_lim;
    logic [31:0]   lifetime;
    tcq_pkg::out_t pending[$];
    tcq_pkg::out_t batch[$];
    int            errors;

    function void reset_state();
      foreach (valid_q[i]) valid_q[i] = 0;
      now_ticks = '0;
      seq_cnt = '0;
      per_key_lim = tcq_pkg::PER_KEY_RST;
      total_lim = tcq_pkg::TOTAL_RST;
      lifetime = tcq_pkg::LIFETIME_RST;
      pending.delete();
      errors = 0;
    endfunction

    function int held();
      int c;
      c = 0;
      foreach (valid_q[i]) if (valid_q[i]) c++;
      return c;
    endfunction

    function bit is_older(int a, int b);
      logic [31:0] aa, ab, oa, ob;
      aa = now_ticks - stamp_q[a];
      ab = now_ticks - stamp_q[b];
      oa = seq_cnt - ord_q[a];
      ob = seq_cnt - ord_q[b];
      if (aa != ab) return aa > ab;
      return oa > ob;
    endfunction

    function void release_slot(int i);
      tcq_pkg::out_t r;
      valid_q[i] = 0;
      r = '0;
      r.kind = 1'b1;
      r.out_handle = hdl_q[i];
      batch = {batch, r};
    endfunction

    function int oldest(bit by_key, logic [31:0] k);
      int best;
      best = -1;
      for (int i = 0; i < NSLOT; i++) begin
        if (!valid_q[i] || (by_key && key_q[i] != k)) continue;
        if (best < 0 || is_older(i, best)) best = i;
      end
      return best;
    endfunction

    function void evict_to_total(int lim);
      int v;
      while (held() > lim) begin
        v = oldest(0, '0);
        if (v < 0) break;
        release_slot(v);
      end
    endfunction

    function void evict_per_key();
      bit have;
      logic [31:0] cand;
      int c, v;
      forever begin
        have = 0;
        cand = '0;
        for (int i = 0; i < NSLOT; i++) begin
          if (!valid_q[i]) continue;
          c = 0;
          for (int j = 0; j < NSLOT; j++) if (valid_q[j] && key_q[j] == key_q[i]) c++;
          if (c > per_key_lim && (!have || key_q[i] < cand)) begin
            have = 1;
            cand = key_q[i];
          end
        end
        if (!have) break;
        v = oldest(1, cand);
        if (v < 0) break;
        release_slot(v);
      end
    endfunction

    function int eff_total();
      return (total_lim < NSLOT) ? total_lim : NSLOT;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        tcq_pkg::REG_PER_KEY:  per_key_lim = val[5:0];
        tcq_pkg::REG_TOTAL:    total_lim = val[5:0];
        tcq_pkg::REG_LIFETIME: lifetime = val;
        default: ;
      endcase
    endfunction

    function void note_input(tcq_pkg::in_t it);
      tcq_pkg::out_t fin;
      int best;
      batch.delete();
      fin = '0;
      fin.last = 1'b1;
      case (it.action)
        tcq_pkg::ACT_STORE: if (it.handle != 0) begin
          if (total_lim == 0 || per_key_lim == 0) begin
            evict_to_total(eff_total());
            evict_per_key();
          end else begin
            evict_to_total(eff_total() - 1);
            for (int i = 0; i < NSLOT; i++) begin
              if (!valid_q[i]) begin
                valid_q[i] = 1;
                key_q[i] = it.key_id;
                hdl_q[i] = it.handle;
                stamp_q[i] = now_ticks;
                ord_q[i] = seq_cnt;
                seq_cnt++;
                break;
              end
            end
            evict_per_key();
          end
        end
        tcq_pkg::ACT_LOOKUP: begin
          best = -1;
          for (int i = 0; i < NSLOT; i++)
            if (valid_q[i] && (now_ticks - stamp_q[i]) > lifetime) release_slot(i);
          for (int i = 0; i < NSLOT; i++) begin
            if (!valid_q[i] || key_q[i] != it.key_id) continue;
            if (best < 0 || is_older(best, i)) best = i;
          end
          if (best >= 0) begin
            fin.found = 1'b1;
            fin.out_handle = hdl_q[best];
          end
        end
        tcq_pkg::ACT_REMOVE:
          for (int i = 0; i < NSLOT; i++)
            if (valid_q[i] && key_q[i] == it.key_id) release_slot(i);
        tcq_pkg::ACT_TICK: now_ticks++;
        tcq_pkg::ACT_TRIM: begin
          evict_to_total(eff_total());
          evict_per_key();
        end
        default: ;
      endcase
      batch = {batch, fin};
      foreach (batch[k]) begin
        batch[k].entry_count = 6'(held());
        pending = {pending, batch[k]};
      end
    endfunction

    task report_err(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_result(tcq_pkg::out_t got);
      tcq_pkg::out_t exp_r;
      if (pending.size() == 0) begin
        report_err($sformatf("unexpected result %p", got));
        return;
      end
      exp_r = pending.pop_front();
      if (got.kind !== exp_r.kind) report_err($sformatf("kind %0d exp %0d", got.kind, exp_r.kind));
      if (got.found !== exp_r.found)
        report_err($sformatf("found %0d exp %0d", got.found, exp_r.found));
      if (got.out_handle !== exp_r.out_handle)
        report_err($sformatf("handle %h exp %h", got.out_handle, exp_r.out_handle));
      if (got.entry_count !== exp_r.entry_count)
        report_err($sformatf("count %0d exp %0d", got.entry_count, exp_r.entry_count));
      if (got.last !== exp_r.last) report_err($sformatf("last %0d exp %0d", got.last, exp_r.last));
    endtask
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  tcq_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  tcq_pkg::out_t out_data_o;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  ticket_cache_with_quotas u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  ticket_scoreboard sb = new();
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int unsigned cycle_cnt = 0;
  logic [31:0] key_pool[4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001};

  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receive side: check on accept, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // hold valid after the accept; the next call or drain sets it in the same step
  task automatic send_item(tcq_pkg::in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
  endtask

  task automatic send_action(logic [2:0] act, logic [31:0] k, logic [31:0] h);
    tcq_pkg::in_t it;
    it.action = act;
    it.key_id = k;
    it.handle = h;
    send_item(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (NSLOT * 8 + 40) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AW'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(logic [5:0] pk, logic [5:0] tot, logic [31:0] life);
    drain();
    apb_write(tcq_pkg::REG_PER_KEY, 32'(pk));
    apb_write(tcq_pkg::REG_TOTAL, 32'(tot));
    apb_write(tcq_pkg::REG_LIFETIME, life);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_items(int n);
    logic [2:0]  act;
    logic [31:0] k, h;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) act = tcq_pkg::ACT_STORE;
      else if (r < 65) act = tcq_pkg::ACT_LOOKUP;
      else if (r < 73) act = tcq_pkg::ACT_REMOVE;
      else if (r < 88) act = tcq_pkg::ACT_TICK;
      else if (r < 96) act = tcq_pkg::ACT_TRIM;
      else act = 3'($urandom_range(ACT_RSVD_HI, ACT_RSVD_LO));
      k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(3)];
      r = $urandom_range(19);
      h = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom();
      send_action(act, k, h);
    end
  endtask

  initial begin
    sb.reset_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: defaults, quota, expiry, zero handle, extremes
    send_action(tcq_pkg::ACT_STORE, 32'h0, 32'h0);
    send_action(tcq_pkg::ACT_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_action(tcq_pkg::ACT_STORE, 32'hFFFF_FFFF, 32'h1);
    send_action(tcq_pkg::ACT_STORE, 32'hFFFF_FFFF, 32'h2);
    send_action(tcq_pkg::ACT_STORE, 32'h0, 32'hAAAA_5555);
    send_action(tcq_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_action(tcq_pkg::ACT_LOOKUP, 32'h5555_AAAA, 32'h0);
    send_action(tcq_pkg::ACT_TICK, 32'h0, 32'h0);
    send_action(tcq_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_action(tcq_pkg::ACT_TRIM, 32'h0, 32'h0);
    send_action(ACT_RSVD_LO, 32'h1, 32'h1);
    send_action(ACT_RSVD_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    configure(6'd0, 6'd63, 32'd0);
    send_action(tcq_pkg::ACT_STORE, 32'h3, 32'h33);
    send_action(tcq_pkg::ACT_TRIM, 32'h0, 32'h0);
    configure(6'd32, 6'd1, 32'hFFFF_FFFF);
    send_action(tcq_pkg::ACT_STORE, 32'h4, 32'h44);
    send_action(tcq_pkg::ACT_STORE, 32'h5, 32'h55);
    configure(6'd32, 6'd32, 32'd0);
    for (int i = 0; i < NSLOT + 2; i++) begin
      send_action(tcq_pkg::ACT_STORE, key_pool[i % 4], 32'(i + 100));
    end
    send_action(tcq_pkg::ACT_TICK, 32'h0, 32'h0);
    send_action(tcq_pkg::ACT_LOOKUP, 32'h0, 32'h0);

    configure(6'd2, 6'd32, 32'd3);
    random_items(60);
    send_idle_pct = 64;
    configure(6'd1, 6'd5, 32'd1);
    random_items(60);
    send_idle_pct = 0;
    stall_pct = 64;
    configure(6'd3, 6'd0, 32'd2);
    random_items(25);
    configure(6'd4, 6'd20, 32'd5);
    random_items(30);
    send_idle_pct = 13;
    stall_pct = 13;
    configure(6'd63, 6'd32, 32'hFFFF_FFFF);
    random_items(53);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
